[rtl/bma_pkg.sv]
// ----------------------------------------------------------------------------
// bma_pkg
// Shared constants and types of the boxcar moving average core.
// ----------------------------------------------------------------------------
package bma_pkg;

   // default build sizes
   localparam int MAX_WINDOW_DEF   = 32;
   localparam int MAX_LENGTH_DEF   = 4096;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // register file
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int WINDOW_REG_W = 6;
   localparam int LENGTH_REG_W = 13;

   localparam logic [WINDOW_REG_W-1:0] WINDOW_RESET = WINDOW_REG_W'(1);
   localparam logic [LENGTH_REG_W-1:0] LENGTH_RESET = LENGTH_REG_W'(4096);

   // register index, taken from paddr[2]
   localparam logic REG_WINDOW = 1'b0;
   localparam logic REG_LENGTH = 1'b1;

   typedef struct packed {
      logic [WINDOW_REG_W-1:0] window_length;
      logic [LENGTH_REG_W-1:0] array_length;
      logic                    restart;
   } csr_cfg_type;

endpackage

[rtl/bma_if.sv]
// ----------------------------------------------------------------------------
// bma_if
// Valid/ready channels of the boxcar moving average core.
// ----------------------------------------------------------------------------
interface bma_req_if #(
   parameter int SAMPLE_WIDTH = bma_pkg::SAMPLE_WIDTH_DEF
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bma_rsp_if #(
   parameter int SAMPLE_WIDTH = bma_pkg::SAMPLE_WIDTH_DEF
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] smoothed;
   logic                    last_of_array;

   modport source (output valid, output smoothed, output last_of_array, input ready);
   modport sink   (input valid, input smoothed, input last_of_array, output ready);
endinterface

[rtl/boxcar_moving_average_core.sv]
// ----------------------------------------------------------------------------
// boxcar_moving_average_core
// Boxcar smoothing of a streamed spectrum with a running window sum,
// a sample history ring and a bit-serial divider.
//
//   channel   dir   handshake            beat contents
//   req_chan  in    valid/ready          sample
//   rsp_chan  out   valid/ready          smoothed, last_of_array
//   csr_*     in    apb write/read       window_length @0, array_length @4
//
// one sample at a time: accept and sum update, then per result a history read
// and a load; an averaged result takes the divider in place of the read, one
// bit per cycle over the sum width (21 at default sizes), before its load.
// the final sample of an array emits up to (window-1)/2+1 beats.
// synchronous reset; no clearing pass. a stalled rsp holds the core in load,
// and a new sample is taken while the last beat still waits in the output reg.
// ----------------------------------------------------------------------------
module boxcar_moving_average_core #(
   parameter int MAX_WINDOW   = bma_pkg::MAX_WINDOW_DEF,
   parameter int MAX_LENGTH   = bma_pkg::MAX_LENGTH_DEF,
   parameter int SAMPLE_WIDTH = bma_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   bma_req_if.sink                        req_chan,
   bma_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bma_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bma_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bma_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int AW     = $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(MAX_LENGTH);
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
   localparam int RING_W = WIN_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUM  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_LOAD = 3'd4;

   bma_pkg::csr_cfg_type cfg;

   logic [2:0]              state_ff, state_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [AW-1:0]           ws_ff, ws_in;
   logic [AW-1:0]           slot_ff;
   logic [SAMPLE_WIDTH-1:0] sample_ff;
   logic [WIN_W-1:0]        k_ff, k_in;
   logic                    final_ff, final_in;
   logic                    avg_ff, avg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_smoothed_ff;
   logic                    rsp_last_ff;

   logic [SAMPLE_WIDTH-1:0] hist_mem [MAX_WINDOW];
   logic [SAMPLE_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]           rd_addr;
   logic                    rd_en;
   logic                    hist_we;

   logic [WIN_W-1:0]        win;
   logic [LEN_W-1:0]        len;
   logic [WIN_W-1:0]        dly;
   logic                    accept;
   logic                    out_free;
   logic                    load_beat;
   logic [SUM_W-1:0]        sub_val;
   logic [SUM_W-1:0]        sum_new;
   logic                    is_final;
   logic                    n_ge_d;
   logic [CNT_W-1:0]        pos;
   logic                    use_avg;
   logic                    has_out;
   logic [WIN_W-1:0]        kmax;
   logic                    div_start;
   logic                    div_done;
   logic [SAMPLE_WIDTH-1:0] div_q;

   function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] slot,
                                                input logic [WIN_W-1:0] back);
      logic [RING_W-1:0] t;
      t = RING_W'(slot) + RING_W'(MAX_WINDOW) - RING_W'(back);
      if (t >= RING_W'(MAX_WINDOW)) begin
         t = t - RING_W'(MAX_WINDOW);
      end
      return t[AW-1:0];
   endfunction

   bma_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bma_div #(
      .SUM_W        (SUM_W),
      .WIN_W        (WIN_W),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (win),
      .done     (div_done),
      .quotient (div_q)
   );

   // effective window and length, clamped into range
   always_comb begin
      if (cfg.window_length == '0) begin
         win = WIN_W'(1);
      end else if (32'(cfg.window_length) > 32'(MAX_WINDOW)) begin
         win = WIN_W'(MAX_WINDOW);
      end else begin
         win = WIN_W'(cfg.window_length);
      end
      if (cfg.array_length == '0) begin
         len = LEN_W'(1);
      end else if (32'(cfg.array_length) > 32'(MAX_LENGTH)) begin
         len = LEN_W'(MAX_LENGTH);
      end else begin
         len = LEN_W'(cfg.array_length);
      end
   end

   assign dly      = (win - WIN_W'(1)) >> 1;
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // item decode, valid in the sum state
   assign sub_val  = (32'(n_ff) >= 32'(win))
                     ? {{(SUM_W-SAMPLE_WIDTH){rd_data_ff[SAMPLE_WIDTH-1]}}, rd_data_ff}
                     : '0;
   assign sum_new  = sum_ff - sub_val
                     + {{(SUM_W-SAMPLE_WIDTH){sample_ff[SAMPLE_WIDTH-1]}}, sample_ff};
   assign is_final = (32'(n_ff) + 32'd1) >= 32'(len);
   assign n_ge_d   = 32'(n_ff) >= 32'(dly);
   assign pos      = CNT_W'(32'(n_ff) - 32'(dly));
   assign use_avg  = n_ge_d && (32'(pos) >= 32'(win))
                     && ((32'(len) - 32'(pos)) >= 32'(win));
   assign has_out  = is_final || n_ge_d;
   assign kmax     = n_ge_d ? dly : WIN_W'(n_ff);

   assign div_start = (state_ff == ST_SUM) && use_avg;
   assign load_beat = (state_ff == ST_LOAD) && out_free;
   assign hist_we   = (state_ff == ST_SUM);

   // one history read port: oldest sample on accept, output tap in the read state
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ring_back(slot_ff, k_ff);
      if (state_ff == ST_IDLE) begin
         rd_en   = accept;
         rd_addr = ring_back(ws_ff, win);
      end else if (state_ff == ST_READ) begin
         rd_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
      if (hist_we) begin
         hist_mem[slot_ff] <= sample_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      sum_in       = sum_ff;
      ws_in        = ws_ff;
      k_in         = k_ff;
      final_in     = final_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            ws_in    = (ws_ff == AW'(MAX_WINDOW - 1)) ? '0 : ws_ff + AW'(1);
            n_in     = is_final ? '0 : n_ff + CNT_W'(1);
            sum_in   = is_final ? '0 : sum_new;
            k_in     = kmax;
            final_in = is_final;
            avg_in   = use_avg;
            if (!has_out) begin
               state_in = ST_IDLE;
            end else if (use_avg) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               avg_in       = 1'b0;
               if (final_ff && (k_ff != '0)) begin
                  k_in     = k_ff - WIN_W'(1);
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // register writes are to arrive only while idle; the core does not enforce it
      if (cfg.restart) begin
         n_in   = '0;
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         sum_ff       <= '0;
         ws_ff        <= '0;
         k_ff         <= '0;
         final_ff     <= 1'b0;
         avg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         sum_ff       <= sum_in;
         ws_ff        <= ws_in;
         k_ff         <= k_in;
         final_ff     <= final_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_chan.sample;
         slot_ff   <= ws_ff;
      end
      if (load_beat) begin
         rsp_smoothed_ff <= avg_ff ? div_q : rd_data_ff;
         rsp_last_ff     <= final_ff && (k_ff == '0);
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.smoothed      = rsp_smoothed_ff;
   assign rsp_chan.last_of_array = rsp_last_ff;

endmodule

[rtl/bma_csr.sv]
// ----------------------------------------------------------------------------
// bma_csr
// APB register file: window length and array length.
// ----------------------------------------------------------------------------
module bma_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bma_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bma_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bma_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output bma_pkg::csr_cfg_type              cfg
);

   logic [bma_pkg::WINDOW_REG_W-1:0] window_ff;
   logic [bma_pkg::LENGTH_REG_W-1:0] length_ff;
   logic                             wr_en;
   logic                             reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= bma_pkg::WINDOW_RESET;
         length_ff <= bma_pkg::LENGTH_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            bma_pkg::REG_WINDOW: window_ff <= csr_pwdata[bma_pkg::WINDOW_REG_W-1:0];
            bma_pkg::REG_LENGTH: length_ff <= csr_pwdata[bma_pkg::LENGTH_REG_W-1:0];
            default:             window_ff <= window_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         bma_pkg::REG_WINDOW: csr_prdata = bma_pkg::CSR_DATA_W'(window_ff);
         bma_pkg::REG_LENGTH: csr_prdata = bma_pkg::CSR_DATA_W'(length_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // any write restarts the array
   assign cfg.window_length = window_ff;
   assign cfg.array_length  = length_ff;
   assign cfg.restart       = wr_en;

endmodule

[rtl/bma_div.sv]
// ----------------------------------------------------------------------------
// bma_div
// Bit-serial restoring divider: signed window sum over window length,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bma_div #(
   parameter int SUM_W        = 21,
   parameter int WIN_W        = 6,
   parameter int SAMPLE_WIDTH = bma_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [SUM_W-1:0]        dividend,
   input  logic [WIN_W-1:0]        divisor,
   output logic                    done,
   output logic [SAMPLE_WIDTH-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0] acc_ff;
   logic [WIN_W-1:0] rem_ff;
   logic [WIN_W-1:0] div_ff;
   logic             neg_ff;
   logic [WIN_W:0]   trial;
   logic             fits;
   logic [WIN_W:0]   trial_sub;
   logic [SUM_W-1:0] q_full;

   assign trial     = {rem_ff, acc_ff[SUM_W-1]};
   assign fits      = trial >= {1'b0, div_ff};
   assign trial_sub = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(SUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // magnitude shifts out at the top, quotient bits shift in at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
         rem_ff <= '0;
         div_ff <= divisor;
         neg_ff <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         acc_ff <= {acc_ff[SUM_W-2:0], fits};
         rem_ff <= fits ? trial_sub[WIN_W-1:0] : trial[WIN_W-1:0];
      end
   end

   assign q_full   = neg_ff ? (SUM_W'(0) - acc_ff) : acc_ff;
   assign quotient = q_full[SAMPLE_WIDTH-1:0];
   assign done     = done_ff;

endmodule
